// ===== design/apba_pkg.sv =====
// ----------------------------------------------------------------------------
// apba_pkg
// Shared types and codes for the arena pool bump allocator: the action and
// status codes, the register indexes, the item formats and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package apba_pkg;

  localparam int AddrW  = 48;
  localparam int SizeW  = 25;
  localparam int HdrW   = 12;
  localparam int IdW    = 4;
  localparam int CntW   = 5;
  localparam int CfgIdxW = 2;

  typedef enum logic [2:0] {
    ACT_ALLOC  = 3'd0,
    ACT_FREE   = 3'd1,
    ACT_RESET  = 3'd2,
    ACT_SAVE   = 3'd3,
    ACT_PUSH   = 3'd4,
    ACT_REVERT = 3'd5,
    ACT_COMMIT = 3'd6,
    ACT_QUERY  = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_ARENA = 3'd1,
    STAT_NO_SPACE = 3'd2,
    STAT_MISMATCH = 3'd3,
    STAT_NOT_USED = 3'd4
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARENA_BYTES  = 2'd0,
    CFG_POOL_BASE    = 2'd1,
    CFG_HEADER_BYTES = 2'd2
  } cfg_idx_t;

  localparam logic [SizeW-1:0] ArenaBytesRst  = 25'd65536;
  localparam logic [AddrW-1:0] PoolBaseRst    = 48'd0;
  localparam logic [HdrW-1:0]  HeaderBytesRst = 12'd32;

  typedef struct packed {
    action_t          action;
    logic [IdW-1:0]   target_id;
    logic [SizeW-1:0] byte_count;
    logic [SizeW-1:0] mark;
  } apba_in_t;

  typedef struct packed {
    status_t          status;
    logic [IdW-1:0]   granted_id;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] saved_mark;
    logic [SizeW-1:0] bytes_free;
    logic [SizeW-1:0] bytes_used;
    logic [CntW-1:0]  arenas_free;
  } apba_out_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } apba_cmd_t;

endpackage

// ===== design/arena_pool_bump_allocator_top.sv =====
// An item is accepted in ST_IDLE, where the arena tables are read into
// registers; in ST_EXEC the step commits, updating the tables and the
// free-list head and registering the result. One item is taken at a time.
// A waiting result holds the step until the output register is taken.
// Reset is synchronous: the free list returns to ids 0 to NUM_ARENAS-1 with
// 0 on top, and per-entry valid bits restore the tables at once.
// ----------------------------------------------------------------------------
// arena_pool_bump_allocator_top
// Pool of equal-size bump arenas with a LIFO free list, a bump position and a
// save mark per arena, driven one action item at a time.
// ----------------------------------------------------------------------------
module arena_pool_bump_allocator_top #(
  parameter int NUM_ARENAS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  apba_pkg::apba_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output apba_pkg::apba_out_t          out_data,
  input  logic                         cfg_write,
  input  logic [apba_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [apba_pkg::AddrW-1:0]   cfg_data
);
  import apba_pkg::*;

  apba_cmd_t cmd;

  apba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  apba_dp #(
    .NUM_ARENAS (NUM_ARENAS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== design/apba_ctrl.sv =====
// ----------------------------------------------------------------------------
// apba_ctrl
// Controller: takes one item, lets the datapath register its arena table
// reads, then commits the step once the output register is free.
// ----------------------------------------------------------------------------
module apba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output apba_pkg::apba_cmd_t cmd
);
  import apba_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The step commits only when its result has a place to go.
        if (!out_valid || !out_stall) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.exec | (out_valid & out_stall);
  end

endmodule

// ===== design/apba_dp.sv =====
// ----------------------------------------------------------------------------
// apba_dp
// Datapath: configuration registers, free-list head, arena tables, the step
// logic for every action and the output register.
// ----------------------------------------------------------------------------
module apba_dp #(
  parameter int NUM_ARENAS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  apba_pkg::apba_cmd_t             cmd,
  input  apba_pkg::apba_in_t              in_data,
  output apba_pkg::apba_out_t             out_data,
  input  logic                            cfg_write,
  input  logic [apba_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [apba_pkg::AddrW-1:0]      cfg_data
);
  import apba_pkg::*;

  localparam int IW = (NUM_ARENAS > 1) ? $clog2(NUM_ARENAS) : 1;
  localparam int TW = $clog2(NUM_ARENAS + 1);

  // Configuration.
  logic [SizeW-1:0] arena_bytes;
  logic [AddrW-1:0] pool_base;
  logic [HdrW-1:0]  header_bytes;

  // Free list head and count.
  logic [TW-1:0] free_top, free_top_next;
  logic [TW-1:0] free_total, free_total_next;

  // Arena tables; entries never written read as their reset values.
  logic [TW-1:0]    link_mem [NUM_ARENAS];
  logic [SizeW-1:0] pos_mem  [NUM_ARENAS];
  logic [SizeW-1:0] save_mem [NUM_ARENAS];
  logic [NUM_ARENAS-1:0] link_vld;
  logic [NUM_ARENAS-1:0] arena_vld;
  logic [NUM_ARENAS-1:0] in_use;

  // Item held for the step.
  action_t            act_r;
  logic [IdW-1:0]     id_r;
  logic [SizeW-1:0]   cnt_r;
  logic [SizeW-1:0]   mark_r;
  logic [IW-1:0]      idx_r;
  logic               ok_r;
  logic [IdW+SizeW-1:0] prod_r;
  logic [AddrW-1:0]   bh_r;
  logic [TW-1:0]      link_rd;
  logic [SizeW-1:0]   pos_rd;
  logic [SizeW-1:0]   save_rd;
  logic               link_v, arena_v, inuse_rd;

  logic [IW-1:0] idx_sel;
  logic          ok_sel;

  // Step results.
  logic [TW-1:0]    link_e;
  logic [SizeW-1:0] pos_e, save_e, room_pos, room_save;
  logic [SizeW-1:0] pos_new, save_new, free_new;
  logic [AddrW-1:0] addr;
  status_t          status;
  logic [IdW-1:0]   gid;
  logic             have, link_we, arena_we, set_use, clr_use;
  apba_out_t        out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_bytes  <= ArenaBytesRst;
      pool_base    <= PoolBaseRst;
      header_bytes <= HeaderBytesRst;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ARENA_BYTES:  arena_bytes  <= cfg_data[SizeW-1:0];
        CFG_POOL_BASE:    pool_base    <= cfg_data;
        CFG_HEADER_BYTES: header_bytes <= cfg_data[HdrW-1:0];
        default: ;
      endcase
    end
  end

  // Which arena the item touches: the list head for alloc, else its id.
  always_comb begin
    if (in_data.action == ACT_ALLOC) begin
      ok_sel = (free_total != '0) && (free_top != TW'(NUM_ARENAS));
      idx_sel = ok_sel ? IW'(free_top) : '0;
    end else begin
      ok_sel = (32'(in_data.target_id) < NUM_ARENAS);
      idx_sel = ok_sel ? IW'(in_data.target_id) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= in_data.action;
      id_r     <= in_data.target_id;
      cnt_r    <= in_data.byte_count;
      mark_r   <= in_data.mark;
      idx_r    <= idx_sel;
      ok_r     <= ok_sel;
      prod_r   <= (IdW+SizeW)'(in_data.target_id) * (IdW+SizeW)'(arena_bytes);
      bh_r     <= pool_base + AddrW'(header_bytes);
      link_rd  <= link_mem[idx_sel];
      pos_rd   <= pos_mem[idx_sel];
      save_rd  <= save_mem[idx_sel];
      link_v   <= link_vld[idx_sel];
      arena_v  <= arena_vld[idx_sel];
      inuse_rd <= in_use[idx_sel];
    end
  end

  always_comb begin
    link_e    = link_v ? link_rd : TW'(idx_r) + TW'(1);
    pos_e     = arena_v ? pos_rd : '0;
    save_e    = arena_v ? save_rd : '0;
    room_pos  = (pos_e < arena_bytes) ? arena_bytes - pos_e : '0;
    room_save = (save_e < arena_bytes) ? arena_bytes - save_e : '0;

    status          = STAT_OK;
    gid             = id_r;
    have            = ok_r;
    addr            = '0;
    pos_new         = pos_e;
    save_new        = save_e;
    free_new        = room_pos;
    free_top_next   = free_top;
    free_total_next = free_total;
    link_we         = 1'b0;
    arena_we        = 1'b0;
    set_use         = 1'b0;
    clr_use         = 1'b0;

    if (act_r == ACT_ALLOC) begin
      if (!ok_r) begin
        status = STAT_NO_ARENA;
        gid    = '0;
      end else begin
        gid             = IdW'(idx_r);
        free_top_next   = link_e;
        free_total_next = free_total - TW'(1);
        set_use         = 1'b1;
        arena_we        = 1'b1;
        pos_new         = '0;
        save_new        = '0;
        free_new        = arena_bytes;
      end
    end else if (!ok_r || !inuse_rd) begin
      status = STAT_NOT_USED;
    end else begin
      case (act_r)
        ACT_FREE: begin
          link_we         = 1'b1;
          free_top_next   = TW'(idx_r);
          free_total_next = free_total + TW'(1);
          clr_use         = 1'b1;
        end
        ACT_RESET: begin
          arena_we = 1'b1;
          pos_new  = '0;
          save_new = '0;
          free_new = arena_bytes;
        end
        ACT_SAVE: begin
          if (save_e != '0) begin
            status = STAT_MISMATCH;
          end else begin
            arena_we = 1'b1;
            save_new = pos_e;
          end
        end
        ACT_PUSH: begin
          if (cnt_r > room_pos) begin
            status = STAT_NO_SPACE;
          end else begin
            arena_we = 1'b1;
            addr     = bh_r + AddrW'(prod_r) + AddrW'(pos_e);
            pos_new  = pos_e + cnt_r;
            // The push fits, so the room left is the old room less the count.
            free_new = room_pos - cnt_r;
          end
        end
        ACT_REVERT: begin
          if (mark_r != save_e) begin
            status = STAT_MISMATCH;
          end else begin
            arena_we = 1'b1;
            pos_new  = save_e;
            save_new = '0;
            free_new = room_save;
          end
        end
        ACT_COMMIT: begin
          if (mark_r != save_e) begin
            status = STAT_MISMATCH;
          end else begin
            arena_we = 1'b1;
            save_new = '0;
          end
        end
        default: ;
      endcase
    end

    out_next.status      = status;
    out_next.granted_id  = gid;
    out_next.address     = addr;
    out_next.saved_mark  = have ? save_new : '0;
    out_next.bytes_free  = have ? free_new : '0;
    out_next.bytes_used  = have ? pos_new : '0;
    out_next.arenas_free = CntW'(free_total_next);
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (link_we) begin
        link_mem[idx_r] <= free_top;
      end
      if (arena_we) begin
        pos_mem[idx_r]  <= pos_new;
        save_mem[idx_r] <= save_new;
      end
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top   <= '0;
      free_total <= TW'(NUM_ARENAS);
      link_vld   <= '0;
      arena_vld  <= '0;
      in_use     <= '0;
    end else if (cmd.exec) begin
      free_top   <= free_top_next;
      free_total <= free_total_next;
      if (link_we) begin
        link_vld[idx_r] <= 1'b1;
      end
      if (set_use) begin
        in_use[idx_r]    <= 1'b1;
        arena_vld[idx_r] <= 1'b1;
      end
      if (clr_use) begin
        in_use[idx_r] <= 1'b0;
      end
    end
  end

endmodule

// ===== design/apba_chk.sv =====
// ----------------------------------------------------------------------------
// apba_chk
// Port-level checks for the arena pool bump allocator, bound to the top level.
// ----------------------------------------------------------------------------
module apba_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input apba_pkg::apba_out_t out_data
);
  import apba_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: the block stalls right after taking an item.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another is in progress");

  // Only a successful push produces an address.
  a_addr_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.address != '0) |-> out_data.status == STAT_OK)
    else $error("address given on a failed step");

  // A failed alloc names no arena and reports no bytes.
  a_no_arena: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STAT_NO_ARENA |->
      out_data.granted_id == '0 && out_data.bytes_used == '0 &&
      out_data.bytes_free == '0 && out_data.arenas_free == '0)
    else $error("failed alloc reported arena data");

endmodule

bind arena_pool_bump_allocator_top apba_chk u_apba_chk (.*);
